/* src/rrss_pkg.sv */
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types and constants for the round-robin server selector: command and
// status codes, transaction payload structs and the controller/datapath link.
// ----------------------------------------------------------------------------
package rrss_pkg;

    // default table depth and id width
    localparam int RRSS_MAX_SERVERS = 16;
    localparam int RRSS_ID_BITS     = 16;

    // width of the id fields on the ports
    localparam int RRSS_FIELD_ID_W  = 16;

    // command codes
    typedef enum logic [2:0] {
        OP_SELECT  = 3'd0,
        OP_ADD     = 3'd1,
        OP_DELETE  = 3'd2,
        OP_ENABLE  = 3'd3,
        OP_DISABLE = 3'd4
    } t_rrss_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONE      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_rrss_status;

    // input transaction
    typedef struct packed {
        logic [2:0]                 command;
        logic [RRSS_FIELD_ID_W-1:0] server_id;
        logic                       initial_enabled;
    } t_rrss_item;

    // result transaction
    typedef struct packed {
        t_rrss_status               status;
        logic [RRSS_FIELD_ID_W-1:0] chosen_server;
    } t_rrss_result;

    // controller to datapath commands
    typedef struct packed {
        logic         capture;
        logic         init_sel;
        logic         init_find;
        logic         init_add;
        logic         init_del;
        logic         run;
        logic         shift_wr;
        logic         head_wr;
        logic         tog_wr;
        logic         upd_sel_ok;
        logic         upd_sel_fail;
        logic         upd_add;
        logic         upd_del;
        logic         finish;
        logic         pick;
        t_rrss_status status;
    } t_rrss_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       eng_idle;
        logic       hit_en;
        logic       hit_id;
    } t_rrss_stat;

endpackage

/* src/round_robin_server_selector_core.sv */
// ----------------------------------------------------------------------------
// round_robin_server_selector_core
// Round-robin server selector over an ordered table of server ids with
// per-entry enable flags: select, add, delete, enable and disable commands.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until its result has been issued, one transaction at a time. The result
// shows on o_result for exactly one cycle with o_done high, and the receiver
// cannot stall it. The slot table is read one entry per cycle through its
// single registered read port: select scans from the next-pick position for
// an enabled entry, add moves the entries down and writes the new one at the
// head, enable/disable search for the id, delete searches for the id up to
// the match, then moves the entries below the removed one. Commands that end
// at once (empty or full table, unknown code) finish from dispatch. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module round_robin_server_selector_core
    import rrss_pkg::*;
#(
    parameter int MAX_SERVERS = RRSS_MAX_SERVERS,
    parameter int ID_BITS     = RRSS_ID_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  t_rrss_item   i_item,
    output logic         busy,
    output logic         o_done,
    output t_rrss_result o_result
);

    t_rrss_cmd  cmd;
    t_rrss_stat stat;

    // command sequencer
    rrss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // slot table and bookkeeping
    rrss_datapath #(
        .MAX_SERVERS (MAX_SERVERS),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

/* src/rrss_datapath.sv */
// ----------------------------------------------------------------------------
// rrss_datapath
// Slot table memory, read/shift engine, next-pick bookkeeping and the result
// register. Driven step by step by the controller.
// ----------------------------------------------------------------------------
module rrss_datapath
    import rrss_pkg::*;
#(
    parameter int MAX_SERVERS = RRSS_MAX_SERVERS,
    parameter int ID_BITS     = RRSS_ID_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_rrss_item   i_item,
    input  t_rrss_cmd    i_cmd,
    output t_rrss_stat   o_stat,
    output logic         o_done,
    output t_rrss_result o_result
);

    localparam int ID_W  = (ID_BITS < RRSS_FIELD_ID_W) ? ID_BITS : RRSS_FIELD_ID_W;
    localparam int IDX_W = $clog2(MAX_SERVERS);
    localparam int CNT_W = $clog2(MAX_SERVERS + 1);
    localparam int ENT_W = ID_W + 1;

    // slot table: enabled flag on top of the id
    logic [ENT_W-1:0] r_mem [MAX_SERVERS];

    logic [2:0]       r_op;
    logic [ID_W-1:0]  r_id;
    logic             r_en;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_left;
    logic [IDX_W-1:0] r_pos;
    logic             r_present;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_start;
    logic [IDX_W-1:0] r_hit;
    logic             r_down;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic [ENT_W-1:0] r_rd_data;
    logic             r_done;
    t_rrss_result     r_result;

    logic [CNT_W-1:0] ptr_inc;
    logic [IDX_W-1:0] ptr_fwd;
    logic [IDX_W-1:0] ptr_next;
    logic [IDX_W-1:0] start_pos;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] rd_idx_ext;
    logic [ID_W-1:0]  rd_id;
    logic             rd_en;
    logic             issue;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    // pointer stepping: forward with wrap at the tail, or downward
    assign ptr_inc  = CNT_W'(r_ptr) + 1'b1;
    assign ptr_fwd  = (ptr_inc == r_count) ? '0 : ptr_inc[IDX_W-1:0];
    assign ptr_next = r_down ? (r_ptr - 1'b1) : ptr_fwd;

    // scan start for select, stale position counts as empty
    assign start_pos = (r_present && (CNT_W'(r_pos) < r_count)) ? r_pos : '0;

    assign count_m1   = r_count - 1'b1;
    assign rd_idx_ext = CNT_W'(r_rd_idx);
    assign rd_id      = r_rd_data[ID_W-1:0];
    assign rd_en      = r_rd_data[ID_W];
    assign issue      = i_cmd.run && (r_left != '0);

    // single write port: shift move, head insert or flag update
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_rd_data;
        if (i_cmd.shift_wr && r_rd_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_down ? (r_rd_idx + 1'b1) : (r_rd_idx - 1'b1);
        end else if (i_cmd.head_wr) begin
            wr_en   = 1'b1;
            wr_data = {r_en, r_id};
        end else if (i_cmd.tog_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_idx;
            wr_data = {(r_op == OP_ENABLE), rd_id};
        end
    end

    // status to controller
    assign o_stat.op       = r_op;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count == CNT_W'(MAX_SERVERS));
    assign o_stat.eng_idle = (r_left == '0) && !r_rd_vld;
    assign o_stat.hit_en   = r_rd_vld && rd_en;
    assign o_stat.hit_id   = r_rd_vld && (rd_id == r_id);

    // control state: table fill, next-pick position, engine counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_left    <= '0;
            r_pos     <= '0;
            r_present <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done   <= i_cmd.finish;
            r_rd_vld <= issue;

            if (i_cmd.init_sel || i_cmd.init_find || i_cmd.init_add) begin
                r_left <= r_count;
            end else if (i_cmd.init_del) begin
                r_left <= count_m1 - rd_idx_ext;
            end else if (issue) begin
                r_left <= r_left - 1'b1;
            end

            if (i_cmd.upd_sel_ok) begin
                if ((rd_idx_ext + 1'b1) < r_count) begin
                    r_pos     <= r_rd_idx + 1'b1;
                    r_present <= 1'b1;
                end else begin
                    r_pos     <= '0;
                    r_present <= 1'b0;
                end
            end else if (i_cmd.upd_sel_fail) begin
                r_pos     <= r_start;
                r_present <= 1'b1;
            end else if (i_cmd.upd_add) begin
                r_count <= r_count + 1'b1;
                if (r_present) begin
                    r_pos <= r_pos + 1'b1;
                end
            end else if (i_cmd.upd_del) begin
                r_count <= count_m1;
                if (r_present) begin
                    if (r_pos == r_hit) begin
                        if (CNT_W'(r_hit) >= count_m1) begin
                            r_present <= 1'b0;
                            r_pos     <= '0;
                        end
                    end else if (r_pos > r_hit) begin
                        r_pos <= r_pos - 1'b1;
                    end
                end
            end
        end
    end

    // payload: captured transaction, engine pointer, memory, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_item.command;
            r_id <= i_item.server_id[ID_W-1:0];
            r_en <= i_item.initial_enabled;
        end

        if (i_cmd.init_sel) begin
            r_ptr   <= start_pos;
            r_start <= start_pos;
            r_down  <= 1'b0;
        end else if (i_cmd.init_find) begin
            r_ptr  <= '0;
            r_down <= 1'b0;
        end else if (i_cmd.init_add) begin
            r_ptr  <= count_m1[IDX_W-1:0];
            r_down <= 1'b1;
        end else if (i_cmd.init_del) begin
            r_ptr  <= r_rd_idx + 1'b1;
            r_hit  <= r_rd_idx;
            r_down <= 1'b0;
        end else if (issue) begin
            r_ptr <= ptr_next;
        end

        if (issue) begin
            r_rd_data <= r_mem[r_ptr];
            r_rd_idx  <= r_ptr;
        end

        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end

        if (i_cmd.finish) begin
            r_result.status        <= i_cmd.status;
            r_result.chosen_server <= i_cmd.pick ? RRSS_FIELD_ID_W'(rd_id) : '0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* src/rrss_ctrl.sv */
// ----------------------------------------------------------------------------
// rrss_ctrl
// Command sequencer: decodes each transaction and steps the datapath through
// its scan and shift passes, then issues the result.
// ----------------------------------------------------------------------------
module rrss_ctrl
    import rrss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_rrss_stat i_stat,
    output t_rrss_cmd  o_cmd,
    output logic       o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEL_SCAN,
        S_FIND,
        S_ADD_SHIFT,
        S_DEL_SHIFT
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op) inside
                    OP_SELECT: begin
                        if (i_stat.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_NONE;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.init_sel = 1'b1;
                            n_state        = S_SEL_SCAN;
                        end
                    end
                    OP_ADD: begin
                        if (i_stat.full) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_FULL;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.init_add = 1'b1;
                            n_state        = S_ADD_SHIFT;
                        end
                    end
                    OP_DELETE, OP_ENABLE, OP_DISABLE: begin
                        if (i_stat.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_NOT_FOUND;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.init_find = 1'b1;
                            n_state         = S_FIND;
                        end
                    end
                    default: begin
                        // unknown command: no change, plain ok
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_OK;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_SEL_SCAN: begin
                if (i_stat.hit_en) begin
                    o_cmd.upd_sel_ok = 1'b1;
                    o_cmd.finish     = 1'b1;
                    o_cmd.pick       = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_IDLE;
                end else if (i_stat.eng_idle) begin
                    // full lap with nothing enabled
                    o_cmd.upd_sel_fail = 1'b1;
                    o_cmd.finish       = 1'b1;
                    o_cmd.status       = ST_NONE;
                    n_state            = S_IDLE;
                end else begin
                    o_cmd.run = 1'b1;
                end
            end
            S_FIND: begin
                if (i_stat.hit_id) begin
                    if (i_stat.op == OP_DELETE) begin
                        o_cmd.init_del = 1'b1;
                        n_state        = S_DEL_SHIFT;
                    end else begin
                        o_cmd.tog_wr = 1'b1;
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_OK;
                        n_state      = S_IDLE;
                    end
                end else if (i_stat.eng_idle) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_NOT_FOUND;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.run = 1'b1;
                end
            end
            S_ADD_SHIFT: begin
                if (i_stat.eng_idle) begin
                    // table moved down, new entry goes to the head
                    o_cmd.head_wr = 1'b1;
                    o_cmd.upd_add = 1'b1;
                    o_cmd.finish  = 1'b1;
                    o_cmd.status  = ST_OK;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.run      = 1'b1;
                    o_cmd.shift_wr = 1'b1;
                end
            end
            S_DEL_SHIFT: begin
                if (i_stat.eng_idle) begin
                    o_cmd.upd_del = 1'b1;
                    o_cmd.finish  = 1'b1;
                    o_cmd.status  = ST_OK;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.run      = 1'b1;
                    o_cmd.shift_wr = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
